@@ hdl/lce_pkg.sv @@
// Shared types, constants and helpers for the line change event encoder.
// No dependencies.
`default_nettype none

package lce_pkg;

    localparam int MAX_LINES   = 32;
    localparam int TICK_W      = 32;
    localparam int IDX_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic KIND_TIME_MARK = 1'b0;
    localparam logic KIND_CHANGE    = 1'b1;

    // One classified sample waiting for the back end
    typedef struct packed {
        logic [TICK_W-1:0]    elapsed;
        logic [MAX_LINES-1:0] changed;
        logic [MAX_LINES-1:0] levels;
    } job_t;

    // Lowest set bit; zero when the word is empty
    function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_LINES-1:0] word);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_LINES - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ hdl/lce_front.sv @@
// Front end: takes samples, keeps the time origin and last level word,
// and pushes a job for every sample after the first that changes a line. Uses lce_pkg.
`default_nettype none

module lce_front
    import lce_pkg::*;
#(
    parameter int NUM_LINES = MAX_LINES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_ready,
    input  wire logic [TICK_W-1:0]    sample_tick,
    input  wire logic [MAX_LINES-1:0] line_levels,
    input  wire logic                 queue_full,
    output logic                      push,
    output job_t                      push_job
);

    localparam logic [MAX_LINES-1:0] LINE_MASK =
        MAX_LINES'((64'd1 << NUM_LINES) - 64'd1);

    logic [TICK_W-1:0]    origin_tick_reg,     origin_tick_next;
    logic [MAX_LINES-1:0] previous_levels_reg, previous_levels_next;
    logic                 origin_taken_reg,    origin_taken_next;

    logic                 accept;
    logic [MAX_LINES-1:0] masked;
    logic [MAX_LINES-1:0] changed;

    assign sample_ready = !queue_full;
    assign accept       = sample_valid && sample_ready;
    assign masked       = line_levels & LINE_MASK;
    assign changed      = masked ^ previous_levels_reg;

    assign push             = accept && origin_taken_reg && (changed != '0);
    assign push_job.elapsed = sample_tick - origin_tick_reg;
    assign push_job.changed = changed;
    assign push_job.levels  = masked;

    always_comb
    begin
        origin_tick_next     = origin_tick_reg;
        previous_levels_next = previous_levels_reg;
        origin_taken_next    = origin_taken_reg;
        if (accept && !origin_taken_reg)
        begin
            // first sample only sets the origin; its levels are dropped
            origin_tick_next  = sample_tick;
            origin_taken_next = 1'b1;
        end
        else if (push)
        begin
            previous_levels_next = masked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_tick_reg     <= '0;
            previous_levels_reg <= '0;
            origin_taken_reg    <= 1'b0;
        end
        else
        begin
            origin_tick_reg     <= origin_tick_next;
            previous_levels_reg <= previous_levels_next;
            origin_taken_reg    <= origin_taken_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lce_queue.sv @@
// Short job queue between the front and back ends.
// Uses job_t and QUEUE_DEPTH from lce_pkg.
`default_nettype none

module lce_queue
    import lce_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lce_back.sv @@
// Back end: turns one job into a time mark and one change per changed line,
// lowest line first, into a registered result stage. Uses lce_pkg.
`default_nettype none

module lce_back
    import lce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              queue_empty,
    input  wire job_t              pop_job,
    output logic                   pop,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic                   event_kind,
    output logic [TICK_W-1:0]      elapsed_ticks,
    output logic [IDX_W-1:0]       line_index,
    output logic                   line_value,
    output logic                   last_of_run
);

    logic                 busy_reg,   busy_next;
    logic [MAX_LINES-1:0] remain_reg, remain_next;
    logic [MAX_LINES-1:0] levels_reg, levels_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg,      kind_next;
    logic [TICK_W-1:0]    elapsed_reg,   elapsed_next;
    logic [IDX_W-1:0]     index_reg,     index_next;
    logic                 value_reg,     value_next;
    logic                 last_reg,      last_next;

    logic                 load;
    logic [IDX_W-1:0]     first_idx;
    logic [MAX_LINES-1:0] cleared;

    assign load      = !out_valid_reg || result_ready;
    assign pop       = load && !busy_reg && !queue_empty;
    assign first_idx = lowest_set(remain_reg);
    assign cleared   = remain_reg & ~(MAX_LINES'(1) << first_idx);

    always_comb
    begin
        busy_next      = busy_reg;
        remain_next    = remain_reg;
        levels_next    = levels_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        elapsed_next   = elapsed_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_CHANGE;
                elapsed_next   = '0;
                index_next     = first_idx;
                value_next     = levels_reg[first_idx];
                last_next      = (cleared == '0);
                remain_next    = cleared;
                busy_next      = (cleared != '0);
            end
            else if (pop)
            begin
                // job always has at least one change, so the mark is never last
                out_valid_next = 1'b1;
                kind_next      = KIND_TIME_MARK;
                elapsed_next   = pop_job.elapsed;
                index_next     = '0;
                value_next     = 1'b0;
                last_next      = 1'b0;
                remain_next    = pop_job.changed;
                levels_next    = pop_job.levels;
                busy_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg  <= remain_next;
        levels_reg  <= levels_next;
        kind_reg    <= kind_next;
        elapsed_reg <= elapsed_next;
        index_reg   <= index_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign event_kind    = kind_reg;
    assign elapsed_ticks = elapsed_reg;
    assign line_index    = index_reg;
    assign line_value    = value_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

@@ hdl/line_change_event_encoder_unit.sv @@
// A sample's first result passes the job queue, then the back end's result register.
// Quiet samples yield no result; a changing one yields a time mark and one change per
// changed line, which the back end gives out one per cycle while result_ready is high.
// Two-entry job queue lets the front keep taking samples while results drain.
// Reset (rst_n, async, active low) clears origin, stored levels and all valids.
// Top level: front end, job queue and back end. Uses lce_pkg and the three
// lce_* submodules.
`default_nettype none

module line_change_event_encoder_unit
    import lce_pkg::*;
#(
    parameter int NUM_LINES = MAX_LINES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire logic [TICK_W-1:0] sample_tick,
    input  wire logic [MAX_LINES-1:0] line_levels,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic                   event_kind,
    output logic [TICK_W-1:0]      elapsed_ticks,
    output logic [IDX_W-1:0]       line_index,
    output logic                   line_value,
    output logic                   last_of_run
);

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    job_t push_job;
    job_t pop_job;

    lce_front #(
        .NUM_LINES (NUM_LINES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_tick  (sample_tick),
        .line_levels  (line_levels),
        .queue_full   (queue_full),
        .push         (push),
        .push_job     (push_job)
    );

    lce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    lce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .pop_job       (pop_job),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .event_kind    (event_kind),
        .elapsed_ticks (elapsed_ticks),
        .line_index    (line_index),
        .line_value    (line_value),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

@@ hdl/lce_checker.sv @@
// Port-level checks for line_change_event_encoder_unit, attached by bind.
// Uses lce_pkg.
`default_nettype none

module lce_checker
    import lce_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic              event_kind,
    input wire logic [TICK_W-1:0] elapsed_ticks,
    input wire logic [IDX_W-1:0]  line_index,
    input wire logic              line_value,
    input wire logic              last_of_run
);

    // stalled result holds, all fields but line_value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(event_kind)
            && $stable(elapsed_ticks) && $stable(line_index) && $stable(last_of_run))
        else $error("result changed while stalled");

    a_mark_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind == KIND_TIME_MARK |->
            !last_of_run && line_index == '0 && !line_value)
        else $error("malformed time mark");

    a_change_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && event_kind == KIND_CHANGE |-> elapsed_ticks == '0)
        else $error("change result carries elapsed ticks");

    // within a run, changes follow back to back in rising line order
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last_of_run |=>
            result_valid && event_kind == KIND_CHANGE
            && ($past(event_kind) == KIND_TIME_MARK || line_index > $past(line_index)))
        else $error("run broken or out of order");

endmodule

bind line_change_event_encoder_unit lce_checker u_lce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .event_kind    (event_kind),
    .elapsed_ticks (elapsed_ticks),
    .line_index    (line_index),
    .line_value    (line_value),
    .last_of_run   (last_of_run)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for line_change_event_encoder_unit.
// Drives timestamped line samples through a table of directed rows and then random traffic.
// Compared with row values or an in-file predictor. Depends on lce_pkg and the unit's RTL.

module testbench;
    import lce_pkg::*;

    localparam int NUM_LINES = MAX_LINES;
    localparam logic [MAX_LINES-1:0] LINE_MASK = {MAX_LINES{1'b1}} >> (MAX_LINES - NUM_LINES);
    localparam int LONG_HOLD = 400;
    localparam longint TIMEOUT_UNITS = 64'd10_000_000;

    typedef struct {
        logic              kind;
        logic [TICK_W-1:0] elapsed;
        logic [IDX_W-1:0]  idx;
        logic              value;
        logic              last;
    } enc_result_t;

    typedef enum {FROM_MODEL, NO_RESULT, ONE_CHANGE} row_form_t;

    typedef struct {
        logic [TICK_W-1:0]    tick;
        logic [MAX_LINES-1:0] levels;
        row_form_t            form;
        logic [TICK_W-1:0]    elapsed;
        logic [IDX_W-1:0]     idx;
        logic                 value;
    } sample_row_t;

    localparam int N_ROWS = 15;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    logic [TICK_W-1:0]    sample_tick = '0;
    logic [MAX_LINES-1:0] line_levels = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic                 event_kind;
    logic [TICK_W-1:0]    elapsed_ticks;
    logic [IDX_W-1:0]     line_index;
    logic                 line_value;
    logic                 last_of_run;

    // predictor state
    logic [TICK_W-1:0]    origin_tick_m = '0;
    logic [MAX_LINES-1:0] stored_levels = '0;
    logic                 origin_seen = 1'b0;

    enc_result_t sample_results[$];
    enc_result_t awaited_results[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          take_idle_pct = 0;
    bit          hold_results = 1'b0;

    logic [TICK_W-1:0]    stim_tick = '0;
    logic [MAX_LINES-1:0] stim_levels = '0;

    // Rows: first sample, no change, single- and multi-line changes, tick wrap and backwards
    sample_row_t directed_rows [N_ROWS] = '{
        '{32'h1234_5678, 32'hFFFF_FFFF, NO_RESULT,  32'h0,         5'd0,  1'b0},
        '{32'h1234_5679, 32'h0000_0000, NO_RESULT,  32'h0,         5'd0,  1'b0},
        '{32'h1234_5680, 32'h0000_0001, ONE_CHANGE, 32'h0000_0008, 5'd0,  1'b1},
        '{32'hFFFF_FFFF, 32'h8000_0001, ONE_CHANGE, 32'hEDCB_A987, 5'd31, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, FROM_MODEL, 32'h0,         5'd0,  1'b0},
        '{32'h0000_0001, 32'hFFFF_FFFF, FROM_MODEL, 32'h0,         5'd0,  1'b0},
        '{32'h1234_5678, 32'hFFFF_FFFF, NO_RESULT,  32'h0,         5'd0,  1'b0},
        '{32'h1234_5678, 32'hFFFF_FFFE, ONE_CHANGE, 32'h0000_0000, 5'd0,  1'b0},
        '{32'h1234_5677, 32'h7FFF_FFFE, ONE_CHANGE, 32'hFFFF_FFFF, 5'd31, 1'b0},
        '{32'h2000_0000, 32'hAAAA_AAAA, FROM_MODEL, 32'h0,         5'd0,  1'b0},
        '{32'h2000_0001, 32'h5555_5555, FROM_MODEL, 32'h0,         5'd0,  1'b0},
        '{32'h2000_0002, 32'h0000_0000, FROM_MODEL, 32'h0,         5'd0,  1'b0},
        '{32'h1234_5778, 32'h0000_0100, ONE_CHANGE, 32'h0000_0100, 5'd8,  1'b1},
        '{32'h1234_5779, 32'h0000_0100, NO_RESULT,  32'h0,         5'd0,  1'b0},
        '{32'h8000_0000, 32'h0001_0100, ONE_CHANGE, 32'h6DCB_A988, 5'd16, 1'b1}
    };

    line_change_event_encoder_unit #(.NUM_LINES(NUM_LINES)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample_tick   (sample_tick),
        .line_levels   (line_levels),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .event_kind    (event_kind),
        .elapsed_ticks (elapsed_ticks),
        .line_index    (line_index),
        .line_value    (line_value),
        .last_of_run   (last_of_run)
    );

    always #5 clk = ~clk;

    // Fills sample_results with what one accepted sample produces
    function automatic void encode_sample(input logic [TICK_W-1:0] tick,
                                          input logic [MAX_LINES-1:0] raw);
        logic [MAX_LINES-1:0] levels;
        logic [MAX_LINES-1:0] flips;
        logic [TICK_W-1:0]    span;
        enc_result_t          r;
        levels = raw & LINE_MASK;
        sample_results.delete();
        if (!origin_seen)
        begin
            // first sample only sets the time origin; its levels are dropped
            origin_tick_m = tick;
            origin_seen = 1'b1;
            return;
        end
        flips = levels ^ stored_levels;
        if (flips == '0)
            return;
        span = tick - origin_tick_m;
        r = '{KIND_TIME_MARK, span, '0, 1'b0, 1'b0};
        sample_results.push_back(r);
        for (int i = 0; i < MAX_LINES; i++)
        begin
            if (flips[i])
            begin
                r = '{KIND_CHANGE, '0, IDX_W'(i), levels[i], 1'b0};
                sample_results.push_back(r);
            end
        end
        sample_results[sample_results.size() - 1].last = 1'b1;
        stored_levels = levels;
    endfunction

    // Returns at the edge where the transfer happens, with the prediction done
    task automatic offer_sample(input logic [TICK_W-1:0] tick,
                                input logic [MAX_LINES-1:0] levels);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 19);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_tick  <= tick;
        line_levels  <= levels;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        encode_sample(tick, levels);
        stim_tick = tick;
        stim_levels = levels;
    endtask

    task automatic queue_predicted();
        foreach (sample_results[i])
            awaited_results.push_back(sample_results[i]);
    endtask

    task automatic run_directed();
        enc_result_t r;
        foreach (directed_rows[n])
        begin
            offer_sample(directed_rows[n].tick, directed_rows[n].levels);
            case (directed_rows[n].form)
                FROM_MODEL: queue_predicted();
                ONE_CHANGE:
                begin
                    r = '{KIND_TIME_MARK, directed_rows[n].elapsed, '0, 1'b0, 1'b0};
                    awaited_results.push_back(r);
                    r = '{KIND_CHANGE, '0, directed_rows[n].idx, directed_rows[n].value, 1'b1};
                    awaited_results.push_back(r);
                end
                default: ;
            endcase
        end
    endtask

    // dense: every sample flips a random set of lines, for the back-pressure phase
    task automatic random_samples(input int count, input bit dense);
        int                   pick;
        logic [TICK_W-1:0]    tick;
        logic [MAX_LINES-1:0] levels;
        logic [MAX_LINES-1:0] flips;
        repeat (count)
        begin
            pick = dense ? 55 : $urandom_range(0, 99);
            flips = '0;
            if (pick < 50)
            begin
                repeat ($urandom_range(1, 3))
                    flips[$urandom_range(0, MAX_LINES - 1)] = 1'b1;
                levels = stim_levels ^ flips;
            end
            else if (pick < 65)
                levels = stim_levels ^ ($urandom() | 32'h1);
            else if (pick < 75)
                levels = stim_levels;
            else if (pick < 80)
                levels = {MAX_LINES{pick[0]}};
            else
                levels = $urandom();
            if ($urandom_range(0, 9) == 0)
                tick = $urandom();
            else
                tick = stim_tick + $urandom_range(1, 1000);
            offer_sample(tick, levels);
            queue_predicted();
        end
    endtask

    // result side: random back-pressure bursts, plus one long hold on request
    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
                result_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 99) < take_idle_pct)
            begin
                gap = $urandom_range(1, 19);
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                result_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        enc_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d elapsed %h index %0d value %0d",
                       event_kind, elapsed_ticks, line_index, line_value);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                    fail_count++;
                end
                if (elapsed_ticks !== want.elapsed)
                begin
                    $error("elapsed_ticks: expected %h, got %h", want.elapsed, elapsed_ticks);
                    fail_count++;
                end
                if (line_index !== want.idx)
                begin
                    $error("line_index: expected %0d, got %0d", want.idx, line_index);
                    fail_count++;
                end
                if (line_value !== want.value)
                begin
                    $error("line_value: expected %0d, got %0d", want.value, line_value);
                    fail_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        take_idle_pct = 20;
        run_directed();
        random_samples(100, 1'b0);

        // long receiver hold while samples keep coming: the job queue fills and stalls input
        send_idle_pct = 0;
        hold_results = 1'b1;
        random_samples(30, 1'b1);
        sample_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);

        send_idle_pct = 25;
        take_idle_pct = 25;
        random_samples(80, 1'b0);

        // closing stretch at full rate on both sides
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_samples(40, 1'b0);

        sample_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hdl/lce_pkg.sv
hdl/lce_front.sv
hdl/lce_queue.sv
hdl/lce_back.sv
hdl/line_change_event_encoder_unit.sv
hdl/lce_checker.sv
tb/sv/testbench.sv
